@@ hw/rtl/lbpt_pkg.sv @@
// Shared constants and codes for the buffer pool tag and replacement unit.
package lbpt_pkg;

  localparam int NumFramesDef    = 64;
  localparam int FileIdWidthDef  = 8;
  localparam int BlockNoWidthDef = 24;

  typedef enum logic [2:0] {
    OpAccess     = 3'd0,
    OpMarkDirty  = 3'd1,
    OpSetPin     = 3'd2,
    OpInvalidate = 3'd3,
    OpFlush      = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    StsHit       = 3'd0,
    StsFreeFill  = 3'd1,
    StsCleanEvct = 3'd2,
    StsDirtyEvct = 3'd3,
    StsAllPinned = 3'd4,
    StsFlushEnt  = 3'd5,
    StsDone      = 3'd6
  } status_e;

endpackage

@@ hw/rtl/lru_buffer_pool_tags_unit.sv @@
// Buffer pool tag store with LRU replacement, pinning, invalidate and flush listing.
// Access runs a tag scan, a recency scan and a recency shift; invalidate runs a tag scan; mark
// dirty and set pin need no scan; flush runs a tag scan and waits on output stall. One item is
// in work at a time; the tag and recency memories each have a read and a write port and are
// swept one entry per cycle, but flush pauses at dirty entries. Reset clears all marks and the
// recency valid bits at once; no clearing pass is needed and items are taken right away.
module lru_buffer_pool_tags_unit #(
  parameter int NUM_FRAMES     = lbpt_pkg::NumFramesDef,
  parameter int FILE_ID_WIDTH  = lbpt_pkg::FileIdWidthDef,
  parameter int BLOCK_NO_WIDTH = lbpt_pkg::BlockNoWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          op_i,
  input  logic [FILE_ID_WIDTH-1:0]            file_id_i,
  input  logic [BLOCK_NO_WIDTH-1:0]           block_no_i,
  input  logic [$clog2(NUM_FRAMES)-1:0]       frame_sel_i,
  input  logic                                pin_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [$clog2(NUM_FRAMES)-1:0]       frame_o,
  output logic [2:0]                          status_o,
  output logic [FILE_ID_WIDTH-1:0]            old_file_id_o,
  output logic [BLOCK_NO_WIDTH-1:0]           old_block_no_o,
  output logic                                last_o
);
  import lbpt_pkg::*;

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int TW = FILE_ID_WIDTH + BLOCK_NO_WIDTH;

  // Main sequencer. The lookup, invalidate and recency scans are pipelined: the address
  // of entry cnt is issued while the entry read in the previous cycle (chk_idx) is checked.
  typedef enum logic [3:0] {
    S_IDLE, S_LOOKUP, S_VSCAN, S_VREAD, S_VTAG, S_PSCAN, S_SHIFT, S_TAIL,
    S_RESULT, S_INV, S_FL_SCAN, S_FL_READ, S_FL_END
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             cnt_q;
  logic                      chk_v_q;
  logic [FW-1:0]             chk_idx_q;
  logic [FILE_ID_WIDTH-1:0]  fid_q;
  logic [BLOCK_NO_WIDTH-1:0] blk_q;
  logic                      free_found_q;
  logic [FW-1:0]             free_q;
  logic [FW-1:0]             tgt_q;
  logic [FW-1:0]             pos_q;
  status_e                   res_st_q;
  logic [TW-1:0]             res_old_q;
  logic                      pend_v_q;
  logic [FW-1:0]             pend_frame_q;
  logic [TW-1:0]             pend_old_q;
  logic [NUM_FRAMES-1:0]     valid_q, dirty_q, pin_q, ord_v_q;

  logic                      out_valid_q;
  logic [FW-1:0]             out_frame_q;
  status_e                   out_status_q;
  logic [TW-1:0]             out_old_q;
  logic                      out_last_q;

  // Tag memory: file id and block number per frame. Contents only count where valid_q is set.
  logic [TW-1:0] tag_mem [NUM_FRAMES];
  logic [TW-1:0] tag_rd_q;
  logic [FW-1:0] tag_raddr;
  logic          tag_we;

  // Recency memory: position to frame, least recent at position 0. A position whose valid
  // bit is still clear reads as its own index.
  logic [FW-1:0] ord_mem [NUM_FRAMES];
  logic [FW-1:0] ord_rd_q, ord_ridx_q, ord_raddr, ord_waddr, ord_wdata, ord_eff;
  logic          ord_rdv_q, ord_we;

  logic          cnt_in;
  logic [FW-1:0] cnt_idx;
  logic          out_free;
  logic          accept;

  assign cnt_in   = (cnt_q < CW'(NUM_FRAMES));
  assign cnt_idx  = cnt_in ? cnt_q[FW-1:0] : '0;
  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;
  assign ord_eff  = ord_rdv_q ? ord_rd_q : ord_ridx_q;

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign frame_o        = out_frame_q;
  assign status_o       = out_status_q;
  assign old_file_id_o  = out_old_q[TW-1:BLOCK_NO_WIDTH];
  assign old_block_no_o = out_old_q[BLOCK_NO_WIDTH-1:0];
  assign last_o         = out_last_q;

  always_comb begin
    tag_raddr = (state_q == S_VREAD) ? tgt_q : cnt_idx;
    tag_we    = (state_q == S_VTAG);
    ord_raddr = cnt_idx;
    ord_we    = 1'b0;
    ord_waddr = chk_idx_q;
    ord_wdata = ord_eff;
    if (state_q == S_SHIFT && chk_v_q) begin
      ord_we = 1'b1;
    end else if (state_q == S_TAIL) begin
      ord_we    = 1'b1;
      ord_waddr = FW'(NUM_FRAMES - 1);
      ord_wdata = tgt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tgt_q] <= {fid_q, blk_q};
    end
    tag_rd_q <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q   <= ord_mem[ord_raddr];
    ord_ridx_q <= ord_raddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      chk_v_q      <= 1'b0;
      chk_idx_q    <= '0;
      free_found_q <= 1'b0;
      pend_v_q     <= 1'b0;
      valid_q      <= '0;
      dirty_q      <= '0;
      pin_q        <= '0;
      ord_v_q      <= '0;
      ord_rdv_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      ord_rdv_q <= ord_v_q[ord_raddr];
      if (ord_we) begin
        ord_v_q[ord_waddr] <= 1'b1;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fid_q        <= file_id_i;
            blk_q        <= block_no_i;
            cnt_q        <= '0;
            chk_v_q      <= 1'b0;
            free_found_q <= 1'b0;
            pend_v_q     <= 1'b0;
            tgt_q        <= '0;
            res_st_q     <= StsDone;
            res_old_q    <= '0;
            case (op_i)
              OpAccess:     state_q <= S_LOOKUP;
              OpInvalidate: state_q <= S_INV;
              OpFlush:      state_q <= S_FL_SCAN;
              OpMarkDirty: begin
                if ({1'b0, frame_sel_i} < (FW+1)'(NUM_FRAMES)) begin
                  dirty_q[frame_sel_i] <= 1'b1;
                end
                state_q <= S_RESULT;
              end
              OpSetPin: begin
                if ({1'b0, frame_sel_i} < (FW+1)'(NUM_FRAMES)) begin
                  pin_q[frame_sel_i] <= pin_value_i;
                end
                state_q <= S_RESULT;
              end
              default: state_q <= S_RESULT;
            endcase
          end
        end

        // Tag lookup; the lowest invalid frame is noted on the way.
        S_LOOKUP: begin
          chk_v_q   <= cnt_in;
          chk_idx_q <= cnt_idx;
          if (cnt_in) begin
            cnt_q <= cnt_q + CW'(1);
            if (!valid_q[cnt_idx] && !free_found_q) begin
              free_found_q <= 1'b1;
              free_q       <= cnt_idx;
            end
          end
          if (chk_v_q && valid_q[chk_idx_q] && tag_rd_q == {fid_q, blk_q}) begin
            tgt_q    <= chk_idx_q;
            res_st_q <= StsHit;
            cnt_q    <= '0;
            chk_v_q  <= 1'b0;
            state_q  <= S_PSCAN;
          end else if (!cnt_in && !chk_v_q) begin
            cnt_q <= '0;
            if (free_found_q) begin
              tgt_q    <= free_q;
              res_st_q <= StsFreeFill;
              state_q  <= S_VREAD;
            end else begin
              state_q <= S_VSCAN;
            end
          end
        end

        // Walk the recency order from least recent for the first unpinned frame.
        S_VSCAN: begin
          chk_v_q   <= cnt_in;
          chk_idx_q <= cnt_idx;
          if (cnt_in) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (chk_v_q && !pin_q[ord_eff]) begin
            tgt_q    <= ord_eff;
            pos_q    <= chk_idx_q;
            res_st_q <= dirty_q[ord_eff] ? StsDirtyEvct : StsCleanEvct;
            chk_v_q  <= 1'b0;
            state_q  <= S_VREAD;
          end else if (!cnt_in && !chk_v_q) begin
            tgt_q    <= '0;
            res_st_q <= StsAllPinned;
            state_q  <= S_RESULT;
          end
        end

        S_VREAD: begin
          state_q <= S_VTAG;
        end

        // Old tags are out of the memory now; the new tags go in this cycle.
        S_VTAG: begin
          res_old_q      <= (res_st_q == StsDirtyEvct) ? tag_rd_q : '0;
          valid_q[tgt_q] <= 1'b1;
          dirty_q[tgt_q] <= 1'b0;
          chk_v_q        <= 1'b0;
          if (res_st_q == StsFreeFill) begin
            cnt_q   <= '0;
            state_q <= S_PSCAN;
          end else begin
            cnt_q   <= CW'(pos_q) + CW'(1);
            state_q <= S_SHIFT;
          end
        end

        // Find where the touched frame sits in the recency order.
        S_PSCAN: begin
          chk_v_q   <= cnt_in;
          chk_idx_q <= cnt_idx;
          if (cnt_in) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (chk_v_q && ord_eff == tgt_q) begin
            pos_q   <= chk_idx_q;
            cnt_q   <= CW'(chk_idx_q) + CW'(1);
            chk_v_q <= 1'b0;
            state_q <= S_SHIFT;
          end
        end

        // Move every later entry down one place; cnt is the read pointer, one ahead.
        S_SHIFT: begin
          chk_v_q   <= cnt_in;
          chk_idx_q <= cnt_idx - FW'(1);
          if (cnt_in) begin
            cnt_q <= cnt_q + CW'(1);
          end else if (!chk_v_q) begin
            state_q <= S_TAIL;
          end
        end

        S_TAIL: begin
          state_q <= S_RESULT;
        end

        S_RESULT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_frame_q  <= tgt_q;
            out_status_q <= res_st_q;
            out_old_q    <= res_old_q;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        S_INV: begin
          chk_v_q   <= cnt_in;
          chk_idx_q <= cnt_idx;
          if (cnt_in) begin
            cnt_q <= cnt_q + CW'(1);
          end
          if (chk_v_q && tag_rd_q[TW-1:BLOCK_NO_WIDTH] == fid_q) begin
            valid_q[chk_idx_q] <= 1'b0;
          end
          if (!cnt_in && !chk_v_q) begin
            state_q <= S_RESULT;
          end
        end

        // Flush holds one found entry back so that the final beat can carry last.
        S_FL_SCAN: begin
          if (!cnt_in) begin
            state_q <= S_FL_END;
          end else if (valid_q[cnt_idx] && dirty_q[cnt_idx]) begin
            state_q <= S_FL_READ;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_FL_READ: begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_q  <= 1'b1;
              out_frame_q  <= pend_frame_q;
              out_status_q <= StsFlushEnt;
              out_old_q    <= pend_old_q;
              out_last_q   <= 1'b0;
            end
            pend_v_q     <= 1'b1;
            pend_frame_q <= cnt_idx;
            pend_old_q   <= tag_rd_q;
            cnt_q        <= cnt_q + CW'(1);
            state_q      <= S_FL_SCAN;
          end
        end

        S_FL_END: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_last_q  <= 1'b1;
            if (pend_v_q) begin
              out_frame_q  <= pend_frame_q;
              out_status_q <= StsFlushEnt;
              out_old_q    <= pend_old_q;
            end else begin
              out_frame_q  <= '0;
              out_status_q <= StsDone;
              out_old_q    <= '0;
            end
            pend_v_q <= 1'b0;
            state_q  <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
